FILE: hdl/sfpi_pkg.sv
package sfpi_pkg;

    localparam int GRID_CELLS  = 1024;
    localparam int CELL_BITS   = $clog2(GRID_CELLS);
    localparam int FRAC_BITS   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int W_BITS      = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Request codes.
    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_PARTICLE = 1'b1;

    // Input beat as seen on the port.
    typedef struct packed {
        logic                          req_type;
        logic [9:0]                    cell_index;
        logic [15:0]                   offset_frac;
        logic signed [VALUE_WIDTH-1:0] load_ex;
        logic signed [VALUE_WIDTH-1:0] load_ey;
        logic signed [VALUE_WIDTH-1:0] load_ez;
        logic signed [VALUE_WIDTH-1:0] load_by;
        logic signed [VALUE_WIDTH-1:0] load_bz;
        logic signed [VALUE_WIDTH-1:0] load_env_re;
        logic signed [VALUE_WIDTH-1:0] load_env_im;
    } t_in_beat;

    // Result beat as seen on the port.
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] e_long;
        logic signed [VALUE_WIDTH-1:0] e_trans_y;
        logic signed [VALUE_WIDTH-1:0] e_trans_z;
        logic signed [VALUE_WIDTH-1:0] b_trans_y;
        logic signed [VALUE_WIDTH-1:0] b_trans_z;
        logic [VALUE_WIDTH-1:0]        env_sq;
        logic                          out_of_range;
    } t_out_beat;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic                   is_load;
        logic                   load_ok;
        logic                   oor;
        logic [CELL_BITS-1:0]   base_cell;
        logic [CELL_BITS-1:0]   cell_up;
        logic [CELL_BITS-1:0]   stag_lo;
        logic [CELL_BITS-1:0]   stag_hi;
        logic [W_BITS-1:0]      w_frac;
        logic [W_BITS-1:0]      w_stag;
        logic [VALUE_WIDTH-1:0] ex;
        logic [VALUE_WIDTH-1:0] ey;
        logic [VALUE_WIDTH-1:0] ez;
        logic [VALUE_WIDTH-1:0] by;
        logic [VALUE_WIDTH-1:0] bz;
        logic [VALUE_WIDTH-1:0] env_re;
        logic [VALUE_WIDTH-1:0] env_im;
    } t_cmd;

endpackage

FILE: hdl/sfpi_if.sv
interface sfpi_in_if;
    import sfpi_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat beat;
    modport source (output valid, output beat, input ready);
    modport sink (input valid, input beat, output ready);
endinterface

interface sfpi_out_if;
    import sfpi_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat beat;
    modport source (output valid, output beat, input ready);
    modport sink (input valid, input beat, output ready);
endinterface

FILE: hdl/sfpi_front.sv
module sfpi_front (
    input  sfpi_pkg::t_in_beat i_beat,
    output sfpi_pkg::t_cmd     o_cmd
);
    import sfpi_pkg::*;

    localparam logic [W_BITS-1:0] W_HALF = W_BITS'(1) << (W_BITS - 1);

    logic [CELL_BITS:0]   cell_ext;
    logic [CELL_BITS-1:0] base_cell;
    logic [W_BITS-1:0]    x;
    logic                 lower_half;

    // Decode the beat into a load or a particle with its neighbor cells.
    always_comb begin
        cell_ext   = (CELL_BITS + 1)'(i_beat.cell_index);
        base_cell  = cell_ext[CELL_BITS-1:0];
        x          = i_beat.offset_frac;
        lower_half = (x < W_HALF);

        o_cmd.is_load   = (i_beat.req_type == REQ_LOAD);
        o_cmd.load_ok   = (cell_ext < (CELL_BITS + 1)'(GRID_CELLS));
        o_cmd.oor       = ((cell_ext + 1'b1) >= (CELL_BITS + 1)'(GRID_CELLS))
                          || (lower_half && (cell_ext == '0));
        o_cmd.base_cell = base_cell;
        o_cmd.cell_up   = base_cell + 1'b1;
        o_cmd.w_frac    = x;
        if (lower_half) begin
            o_cmd.stag_lo = base_cell - 1'b1;
            o_cmd.stag_hi = base_cell;
            o_cmd.w_stag  = x + W_HALF;
        end else begin
            o_cmd.stag_lo = base_cell;
            o_cmd.stag_hi = base_cell + 1'b1;
            o_cmd.w_stag  = x - W_HALF;
        end
        o_cmd.ex     = i_beat.load_ex;
        o_cmd.ey     = i_beat.load_ey;
        o_cmd.ez     = i_beat.load_ez;
        o_cmd.by     = i_beat.load_by;
        o_cmd.bz     = i_beat.load_bz;
        o_cmd.env_re = i_beat.load_env_re;
        o_cmd.env_im = i_beat.load_env_im;
    end

endmodule

FILE: hdl/sfpi_queue.sv
module sfpi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sfpi_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output sfpi_pkg::t_cmd  o_cmd
);
    import sfpi_pkg::*;

    t_cmd                 r_slot [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: hdl/sfpi_back.sv
module sfpi_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  sfpi_pkg::t_cmd i_cmd,
    output logic           o_pop,
    sfpi_out_if.source     o_out
);
    import sfpi_pkg::*;

    localparam int VW   = VALUE_WIDTH;
    localparam int PW   = VW + W_BITS + 1;
    localparam int SQW  = 2 * VW;
    localparam logic [VW-1:0]     VSIGN  = VW'(1) << (VW - 1);
    localparam logic [W_BITS:0]   W_ONE  = (W_BITS + 1)'(1) << W_BITS;
    localparam logic [PW:0]       W_HALF = (PW + 1)'(1) << (W_BITS - 1);
    localparam logic [SQW:0]      R_HALF = (SQW + 1)'(1) << (FRAC_BITS - 1);
    localparam int NLANE = 6;
    localparam int NFLD  = 5;

    // Field stores, one entry per grid cell.
    logic [VW-1:0] r_ex_mem  [GRID_CELLS];
    logic [VW-1:0] r_ey_mem  [GRID_CELLS];
    logic [VW-1:0] r_ez_mem  [GRID_CELLS];
    logic [VW-1:0] r_by_mem  [GRID_CELLS];
    logic [VW-1:0] r_bz_mem  [GRID_CELLS];
    logic [VW-1:0] r_re_mem  [GRID_CELLS];
    logic [VW-1:0] r_im_mem  [GRID_CELLS];

    logic adv;

    // Stage 1: read data.
    logic              r_s1_valid, r_s1_oor;
    logic [W_BITS-1:0] r_s1_wf, r_s1_ws;
    logic [VW-1:0]     r_s1_flo [NFLD];
    logic [VW-1:0]     r_s1_fhi [NFLD];
    logic [VW-1:0]     r_s1_re  [2];
    logic [VW-1:0]     r_s1_im  [2];
    // Stage 2: magnitudes.
    logic              r_s2_valid, r_s2_oor;
    logic [W_BITS-1:0] r_s2_wf, r_s2_ws;
    logic [VW-1:0]     r_s2_flo [NFLD];
    logic [VW-1:0]     r_s2_fhi [NFLD];
    logic [VW-1:0]     r_s2_mre [2];
    logic [VW-1:0]     r_s2_mim [2];
    // Stage 3: squares.
    logic              r_s3_valid, r_s3_oor;
    logic [W_BITS-1:0] r_s3_wf, r_s3_ws;
    logic [VW-1:0]     r_s3_flo [NFLD];
    logic [VW-1:0]     r_s3_fhi [NFLD];
    logic [SQW-1:0]    r_s3_sre [2];
    logic [SQW-1:0]    r_s3_sim [2];
    // Stage 4: cell powers.
    logic              r_s4_valid, r_s4_oor;
    logic [W_BITS-1:0] r_s4_wf, r_s4_ws;
    logic [VW-1:0]     r_s4_flo [NFLD];
    logic [VW-1:0]     r_s4_fhi [NFLD];
    logic [VW-1:0]     r_s4_pow [2];
    // Stage 5: blend products per lane.
    logic              r_s5_valid, r_s5_oor;
    logic [PW-1:0]     r_s5_plo [NLANE];
    logic [PW-1:0]     r_s5_phi [NLANE];
    // Stage 6: output register.
    logic              r_s6_valid;
    t_out_beat         r_s6_beat;

    logic [SQW:0]      pow_sum [2];
    logic [SQW-FRAC_BITS:0] pow_shr [2];
    logic [VW-1:0]     pow_sat [2];
    logic [VW-1:0]     lane_lo [NLANE];
    logic [VW-1:0]     lane_hi [NLANE];
    logic [W_BITS-1:0] lane_w  [NLANE];
    logic [PW:0]       lane_sum [NLANE];
    logic [VW-1:0]     lane_res [NLANE];

    // The whole pipeline moves whenever the output register can take a beat.
    assign adv   = !r_s6_valid || o_out.ready;
    assign o_pop = adv && !i_empty;

    assign o_out.valid = r_s6_valid;
    assign o_out.beat  = r_s6_beat;

    // Store writes for loads and registered reads of both neighbor pairs.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (o_pop && i_cmd.is_load && i_cmd.load_ok) begin
                r_ex_mem[i_cmd.base_cell] <= i_cmd.ex;
                r_ey_mem[i_cmd.base_cell] <= i_cmd.ey;
                r_ez_mem[i_cmd.base_cell] <= i_cmd.ez;
                r_by_mem[i_cmd.base_cell] <= i_cmd.by;
                r_bz_mem[i_cmd.base_cell] <= i_cmd.bz;
                r_re_mem[i_cmd.base_cell] <= i_cmd.env_re;
                r_im_mem[i_cmd.base_cell] <= i_cmd.env_im;
            end
            r_s1_flo[0] <= r_ex_mem[i_cmd.stag_lo];
            r_s1_fhi[0] <= r_ex_mem[i_cmd.stag_hi];
            r_s1_flo[1] <= r_ey_mem[i_cmd.base_cell];
            r_s1_fhi[1] <= r_ey_mem[i_cmd.cell_up];
            r_s1_flo[2] <= r_ez_mem[i_cmd.base_cell];
            r_s1_fhi[2] <= r_ez_mem[i_cmd.cell_up];
            r_s1_flo[3] <= r_by_mem[i_cmd.stag_lo];
            r_s1_fhi[3] <= r_by_mem[i_cmd.stag_hi];
            r_s1_flo[4] <= r_bz_mem[i_cmd.stag_lo];
            r_s1_fhi[4] <= r_bz_mem[i_cmd.stag_hi];
            r_s1_re[0]  <= r_re_mem[i_cmd.base_cell];
            r_s1_re[1]  <= r_re_mem[i_cmd.cell_up];
            r_s1_im[0]  <= r_im_mem[i_cmd.base_cell];
            r_s1_im[1]  <= r_im_mem[i_cmd.cell_up];
            r_s1_wf     <= i_cmd.w_frac;
            r_s1_ws     <= i_cmd.w_stag;
            r_s1_oor    <= i_cmd.oor;
        end
    end

    // Valid bits of the stages; loads leave no result behind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= o_pop && !i_cmd.is_load;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
        end
    end

    // Power rounding and saturation.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            pow_sum[c] = {1'b0, r_s3_sre[c]} + {1'b0, r_s3_sim[c]} + R_HALF;
            pow_shr[c] = pow_sum[c][SQW:FRAC_BITS];
            if (|pow_shr[c][SQW-FRAC_BITS:VW]) begin
                pow_sat[c] = '1;
            end else begin
                pow_sat[c] = pow_shr[c][VW-1:0];
            end
        end
    end

    // Lane operands: fields in offset binary, the envelope power as is.
    always_comb begin
        for (int l = 0; l < NFLD; l++) begin
            lane_lo[l] = r_s4_flo[l] ^ VSIGN;
            lane_hi[l] = r_s4_fhi[l] ^ VSIGN;
        end
        lane_lo[5] = r_s4_pow[0];
        lane_hi[5] = r_s4_pow[1];
        lane_w[0]  = r_s4_ws;
        lane_w[1]  = r_s4_wf;
        lane_w[2]  = r_s4_wf;
        lane_w[3]  = r_s4_ws;
        lane_w[4]  = r_s4_ws;
        lane_w[5]  = r_s4_wf;
    end

    // Final rounding of each blend, back to two's complement for fields.
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            lane_sum[l] = {1'b0, r_s5_plo[l]} + {1'b0, r_s5_phi[l]} + W_HALF;
            lane_res[l] = lane_sum[l][W_BITS +: VW];
        end
        for (int l = 0; l < NFLD; l++) begin
            lane_res[l] = lane_res[l] ^ VSIGN;
        end
    end

    // Datapath stages 2 to 6.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_oor <= r_s1_oor;
            r_s2_wf  <= r_s1_wf;
            r_s2_ws  <= r_s1_ws;
            r_s2_flo <= r_s1_flo;
            r_s2_fhi <= r_s1_fhi;
            for (int c = 0; c < 2; c++) begin
                r_s2_mre[c] <= r_s1_re[c][VW-1] ? (~r_s1_re[c] + 1'b1) : r_s1_re[c];
                r_s2_mim[c] <= r_s1_im[c][VW-1] ? (~r_s1_im[c] + 1'b1) : r_s1_im[c];
            end

            r_s3_oor <= r_s2_oor;
            r_s3_wf  <= r_s2_wf;
            r_s3_ws  <= r_s2_ws;
            r_s3_flo <= r_s2_flo;
            r_s3_fhi <= r_s2_fhi;
            for (int c = 0; c < 2; c++) begin
                r_s3_sre[c] <= SQW'(r_s2_mre[c]) * SQW'(r_s2_mre[c]);
                r_s3_sim[c] <= SQW'(r_s2_mim[c]) * SQW'(r_s2_mim[c]);
            end

            r_s4_oor <= r_s3_oor;
            r_s4_wf  <= r_s3_wf;
            r_s4_ws  <= r_s3_ws;
            r_s4_flo <= r_s3_flo;
            r_s4_fhi <= r_s3_fhi;
            r_s4_pow <= pow_sat;

            r_s5_oor <= r_s4_oor;
            for (int l = 0; l < NLANE; l++) begin
                r_s5_plo[l] <= PW'(W_ONE - (W_BITS + 1)'(lane_w[l])) * PW'(lane_lo[l]);
                r_s5_phi[l] <= PW'(lane_w[l]) * PW'(lane_hi[l]);
            end

            // A missing neighbor gives all fields zero with only the flag set.
            if (r_s5_oor) begin
                r_s6_beat <= {{(6 * VW){1'b0}}, 1'b1};
            end else begin
                r_s6_beat.e_long       <= lane_res[0];
                r_s6_beat.e_trans_y    <= lane_res[1];
                r_s6_beat.e_trans_z    <= lane_res[2];
                r_s6_beat.b_trans_y    <= lane_res[3];
                r_s6_beat.b_trans_z    <= lane_res[4];
                r_s6_beat.env_sq       <= lane_res[5];
                r_s6_beat.out_of_range <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/staggered_field_to_particle_interp_unit.sv
// One-dimensional staggered field gather. A load beat writes one cell of
// the seven field stores; a particle beat returns Ex, By and Bz blended on
// the half-shifted grid, Ey and Ez blended between its cell and the next,
// and the rounded, saturated envelope power blended the same way, with a
// zero, flagged result when a neighbor cell is missing. The block takes
// one beat per cycle while the queue has room: the front end classifies
// each beat in the cycle it arrives and pushes it into a four-entry
// queue, and the back end drains that queue at one beat per cycle while
// the result side takes beats, through a six-stage pipeline (store read,
// magnitude, square, power round, blend multiply, blend round into the
// output register). Stores are dual-read at the two neighbor cells; a
// stall on the result side holds the back end while the queue keeps
// taking beats until it fills. Store entries are undefined until loaded.
module staggered_field_to_particle_interp_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfpi_in_if.sink    i_in,
    sfpi_out_if.source o_out
);
    import sfpi_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;
    logic queue_push;

    assign i_in.ready = !queue_full;
    assign queue_push = i_in.valid && !queue_full;

    // Classification of incoming beats.
    sfpi_front u_front (
        .i_beat (i_in.beat),
        .o_cmd  (front_cmd)
    );

    // Queue between the two halves.
    sfpi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_cmd   (queue_cmd)
    );

    // Stores and interpolation pipeline.
    sfpi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (queue_empty),
        .i_cmd   (queue_cmd),
        .o_pop   (queue_pop),
        .o_out   (o_out)
    );

endmodule

FILE: dv/sfpi_gather_scoreboard.sv
`timescale 1ns / 100ps

// Predicts gather results and compares them with the block's result beats.
class sfpi_gather_scoreboard;

    logic [31:0] ex_mem[1024];
    logic [31:0] ey_mem[1024];
    logic [31:0] ez_mem[1024];
    logic [31:0] by_mem[1024];
    logic [31:0] bz_mem[1024];
    logic [31:0] re_mem[1024];
    logic [31:0] im_mem[1024];
    sfpi_pkg::t_out_beat pending_fields[$];
    int error_count;

    function new();
        error_count = 0;
        for (int k = 0; k < 1024; k++) begin
            ex_mem[k] = '0; ey_mem[k] = '0; ez_mem[k] = '0;
            by_mem[k] = '0; bz_mem[k] = '0; re_mem[k] = '0; im_mem[k] = '0;
        end
    endfunction

    // Unsigned linear blend with the weight on the upper value.
    function logic [31:0] mix_u(logic [31:0] lo, logic [31:0] hi, logic [16:0] w);
        logic [63:0] acc;
        acc = (64'd65536 - w) * lo + w * hi + 64'd32768;
        return acc[47:16];
    endfunction

    // Signed blend done in offset binary.
    function logic [31:0] mix_s(logic [31:0] lo, logic [31:0] hi, logic [16:0] w);
        return mix_u(lo ^ 32'h8000_0000, hi ^ 32'h8000_0000, w) ^ 32'h8000_0000;
    endfunction

    function logic [31:0] mag(logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Rounded, saturated envelope power of one cell.
    function logic [31:0] power_of(logic [31:0] re, logic [31:0] im);
        logic [65:0] sum;
        sum = ({34'd0, mag(re)} * mag(re)) + ({34'd0, mag(im)} * mag(im)) + 66'd32768;
        sum = sum >> 16;
        return (sum > 66'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Notes one accepted input beat: a store write or an expected result.
    function void note_input(sfpi_pkg::t_in_beat b);
        sfpi_pkg::t_out_beat r;
        int c, lo, hi;
        logic [16:0] w, ws;
        if (b.req_type == sfpi_pkg::REQ_LOAD) begin
            c = int'(b.cell_index);
            ex_mem[c] = b.load_ex; ey_mem[c] = b.load_ey; ez_mem[c] = b.load_ez;
            by_mem[c] = b.load_by; bz_mem[c] = b.load_bz;
            re_mem[c] = b.load_env_re; im_mem[c] = b.load_env_im;
            return;
        end
        r = '0;
        c = int'(b.cell_index);
        w = 17'(b.offset_frac);
        if (c >= 1023 || (c == 0 && !b.offset_frac[15])) begin
            r.out_of_range = 1'b1;
        end else begin
            if (!b.offset_frac[15]) begin
                lo = c - 1; hi = c; ws = w + 17'd32768;
            end else begin
                lo = c; hi = c + 1; ws = w - 17'd32768;
            end
            r.e_long = mix_s(ex_mem[lo], ex_mem[hi], ws);
            r.e_trans_y = mix_s(ey_mem[c], ey_mem[c + 1], w);
            r.e_trans_z = mix_s(ez_mem[c], ez_mem[c + 1], w);
            r.b_trans_y = mix_s(by_mem[lo], by_mem[hi], ws);
            r.b_trans_z = mix_s(bz_mem[lo], bz_mem[hi], ws);
            r.env_sq = mix_u(power_of(re_mem[c], im_mem[c]),
                             power_of(re_mem[c + 1], im_mem[c + 1]), w);
        end
        pending_fields.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // Compares one result beat with the oldest expectation.
    task check_result(sfpi_pkg::t_out_beat g);
        sfpi_pkg::t_out_beat e;
        if (pending_fields.size() == 0) begin
            report_mismatch("unexpected result", g.e_long, 32'd0);
            return;
        end
        e = pending_fields.pop_front();
        if (g.e_long !== e.e_long) report_mismatch("e_long", g.e_long, e.e_long);
        if (g.e_trans_y !== e.e_trans_y)
            report_mismatch("e_trans_y", g.e_trans_y, e.e_trans_y);
        if (g.e_trans_z !== e.e_trans_z)
            report_mismatch("e_trans_z", g.e_trans_z, e.e_trans_z);
        if (g.b_trans_y !== e.b_trans_y)
            report_mismatch("b_trans_y", g.b_trans_y, e.b_trans_y);
        if (g.b_trans_z !== e.b_trans_z)
            report_mismatch("b_trans_z", g.b_trans_z, e.b_trans_z);
        if (g.env_sq !== e.env_sq) report_mismatch("env_sq", g.env_sq, e.env_sq);
        if (g.out_of_range !== e.out_of_range)
            report_mismatch("out_of_range", 32'(g.out_of_range), 32'(e.out_of_range));
    endtask

endclass

FILE: dv/staggered_field_to_particle_interp_unit_tb.sv
`timescale 1ns / 100ps

module staggered_field_to_particle_interp_unit_tb;
    import sfpi_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int cycle_count = 0;
    bit calm_phase = 0;
    bit hold_sink = 0;
    bit loaded[1024];

    sfpi_in_if in_ch();
    sfpi_out_if out_ch();
    sfpi_gather_scoreboard gather_sb;

    staggered_field_to_particle_interp_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    // Cycle counter with a generous timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("FAIL staggered_field_to_particle_interp_unit");
            $finish;
        end
    end

    // Input and result beats are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) gather_sb.note_input(in_ch.beat);
        if (i_rst_n && out_ch.valid && out_ch.ready) gather_sb.check_result(out_ch.beat);
    end

    // Result side ready with random stall bursts and forced hold-offs.
    initial begin
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                out_ch.ready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 131071) - 65536;
            default: return $urandom;
        endcase
    endfunction

    // Drives one beat and waits for its acceptance.
    task automatic send_beat(t_in_beat b);
        int n;
        if (!calm_phase && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.beat <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (b.req_type == REQ_LOAD) loaded[b.cell_index] = 1;
    endtask

    task automatic send_load(int c, logic [31:0] v);
        t_in_beat b;
        b = '0;
        b.req_type = REQ_LOAD;
        b.cell_index = 10'(c);
        b.offset_frac = 16'($urandom);
        b.load_ex = (v == 0) ? rand_value() : v;
        b.load_ey = (v == 0) ? rand_value() : v;
        b.load_ez = (v == 0) ? rand_value() : v;
        b.load_by = (v == 0) ? rand_value() : v;
        b.load_bz = (v == 0) ? rand_value() : v;
        b.load_env_re = (v == 0) ? rand_value() : v;
        b.load_env_im = (v == 0) ? rand_value() : v;
        send_beat(b);
    endtask

    // A particle only touches cells that were loaded, unless flagged anyway.
    task automatic send_particle(int c, logic [15:0] x);
        t_in_beat b;
        b = '0;
        b.req_type = REQ_PARTICLE;
        b.cell_index = 10'(c);
        b.offset_frac = x;
        b.load_ex = $urandom; b.load_ey = $urandom; b.load_ez = $urandom;
        b.load_by = $urandom; b.load_bz = $urandom;
        b.load_env_re = $urandom; b.load_env_im = $urandom;
        send_beat(b);
    endtask

    function automatic bit particle_ok(int c, logic [15:0] x);
        if (c >= 1023 || (c == 0 && !x[15])) return 1;
        if (!loaded[c] || !loaded[c + 1]) return 0;
        if (!x[15] && !loaded[c - 1]) return 0;
        return 1;
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (gather_sb.pending_fields.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        int c;
        logic [15:0] x;
        gather_sb = new();
        in_ch.valid = 1'b0;
        in_ch.beat = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: edge values, edge cells, flagged cases, half-point weights.
        send_load(0, 32'h7FFF_FFFF);
        send_load(1, 32'h8000_0000);
        send_load(2, 32'hFFFF_FFFF);
        send_load(1021, 0);
        send_load(1022, 32'h0001_0000);
        send_load(1023, 32'h8000_0000);
        send_load(3, 0);
        send_particle(0, 16'h0000);
        send_particle(0, 16'h7FFF);
        send_particle(0, 16'h8000);
        send_particle(1, 16'h0000);
        send_particle(1, 16'hFFFF);
        send_particle(1, 16'h8000);
        send_particle(2, 16'h7FFF);
        send_particle(2, 16'h5555);
        send_particle(1022, 16'hAAAA);
        send_particle(1022, 16'h0001);
        send_particle(1023, 16'hFFFF);
        send_particle(1023, 16'h0000);
        send_particle(1021, 16'h8000);
        drain();

        // Fill all cells with random values so random particles are legal.
        for (int k = 0; k < 1024; k++) send_load(k, 0);

        // Random mix of loads and particles.
        for (int k = 0; k < 1000; k++) begin
            if (k == 350) begin
                // Sender pause until all results are back.
                drain();
            end
            if (k == 500) begin
                fork
                    begin
                        hold_sink = 1;
                        repeat (200) @(negedge i_clk);
                        hold_sink = 0;
                    end
                join_none
            end
            if (k == 850) calm_phase = 1;
            if ($urandom_range(0, 4) == 0) begin
                send_load($urandom_range(0, 1023), 0);
            end else begin
                c = ($urandom_range(0, 9) == 0) ? $urandom_range(1020, 1023)
                                                 : $urandom_range(0, 1023);
                x = 16'($urandom);
                if (particle_ok(c, x)) send_particle(c, x);
            end
        end
        in_ch.valid <= 1'b0;
        while (gather_sb.pending_fields.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (gather_sb.error_count == 0) begin
            $display("PASS staggered_field_to_particle_interp_unit");
        end else begin
            $display("FAIL staggered_field_to_particle_interp_unit");
        end
        $finish;
    end

endmodule
